// ----- rtl/core/dim_pkg.sv -----
// Shared constants for the dimuon invariant mass unit
package dim_pkg;
  localparam int MASS_BITS   = 20;
  localparam int PAIR_BITS   = 22;
  localparam int ENERGY_BITS = 21;
endpackage

// ----- rtl/core/dim_if.sv -----
// Valid/ready channel interface with a generic payload
interface dim_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/dim_sqrt_cell.sv -----
// One digit stage of a pipelined restoring square root
module dim_sqrt_cell #(
  parameter int RW  = 8,
  parameter int XW  = 16,
  parameter int BIT = 0,
  parameter int SW  = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x_in,
  input  logic [RW-1:0] r_in,
  input  logic [SW-1:0] side_in,
  output logic [XW-1:0] x_out,
  output logic [RW-1:0] r_out,
  output logic [SW-1:0] side_out
);
  logic [XW-1:0] x_r;
  logic [RW-1:0] r_r;
  logic [SW-1:0] side_r;
  logic [RW-1:0] t;
  logic [2*RW-1:0] sq;

  assign t  = r_in | (RW'(1) << BIT);
  assign sq = {{RW{1'b0}}, t} * {{RW{1'b0}}, t};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_in;
      side_r <= side_in;
      if ((2*RW >= XW) ? (sq <= (2*RW)'(x_in)) : (XW'(sq) <= x_in)) begin
        r_r <= t;
      end else begin
        r_r <= r_in;
      end
    end
  end

  assign x_out    = x_r;
  assign r_out    = r_r;
  assign side_out = side_r;
endmodule

// ----- rtl/core/dim_sqrt_chain.sv -----
// Chain of square-root cells, one result bit per cell
module dim_sqrt_chain #(
  parameter int RW = 8,
  parameter int XW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x_in,
  input  logic [SW-1:0] side_in,
  output logic [RW-1:0] r_out,
  output logic [SW-1:0] side_out
);
  logic [XW-1:0] x_c [RW+1];
  logic [RW-1:0] r_c [RW+1];
  logic [SW-1:0] s_c [RW+1];

  assign x_c[0] = x_in;
  assign r_c[0] = '0;
  assign s_c[0] = side_in;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    dim_sqrt_cell #(.RW(RW), .XW(XW), .BIT(RW-1-i), .SW(SW)) u_cell (
      .clk(clk), .en(en), .x_in(x_c[i]), .r_in(r_c[i]), .side_in(s_c[i]),
      .x_out(x_c[i+1]), .r_out(r_c[i+1]), .side_out(s_c[i+1])
    );
  end

  assign r_out    = r_c[RW];
  assign side_out = s_c[RW];
endmodule

// ----- rtl/core/dimuon_invariant_mass_unit.sv -----
// Dimuon invariant mass unit: top level
// Fully pipelined: one pair per clock while the output is not stalled,
// with EW = max(MOMENTUM_BITS, 20) + 2.
// The pipeline is the input stage, the energy-square stage, the two energy
// chains side by side (one cell per result bit, EW cells), the difference
// stage, the mass chain (EW+1 cells) and the output register. The whole
// pipeline advances when the output register is empty or its result
// transfers; the particle mass is sampled on entry.
module dimuon_invariant_mass_unit
  import dim_pkg::*;
#(
  parameter int MOMENTUM_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [MASS_BITS-1:0] cfg_wdata,
  dim_if.sink                  in_ch,
  dim_if.source                out_ch
);
  localparam int MB  = MOMENTUM_BITS;
  localparam int EW  = ((MB > MASS_BITS) ? MB : MASS_BITS) + 2;
  localparam int E2W = 2 * EW;
  localparam int SMW = MB + 1;
  localparam int MW  = EW + 1;
  localparam int M2W = 2 * MW;
  localparam int L1  = 2 + EW;
  localparam int SW1 = EW;
  localparam int SW2 = 2 * EW + 1;

  logic [MASS_BITS-1:0] mass_r;
  logic en;
  logic [L1:0] v1_r;
  logic [EW:0] v2_r;
  logic out_v_r;

  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= MASS_BITS'(106);
    end else if (cfg_we) begin
      mass_r <= cfg_wdata;
    end
  end

  logic signed [MB-1:0] p [6];
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      p[k] = $signed(in_ch.data[k*MB +: MB]);
    end
  end

  logic [EW-1:0] a_r [6];
  logic [SMW-1:0] s_r [3];
  logic [MASS_BITS-1:0] m_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        a_r[k] <= p[k][MB-1] ? EW'(-$signed({p[k][MB-1], p[k]})) : EW'(p[k]);
      end
      for (int k = 0; k < 3; k++) begin
        s_r[k] <= SMW'($signed(p[k]) + $signed(p[k+3]));
      end
      m_r <= mass_r;
    end
  end

  logic [E2W-1:0] e2a_r, e2b_r;
  logic [E2W-1:0] sd1_r;
  logic [2*SMW-1:0] sq [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq[k] = s_r[k][SMW-1] ? {{SMW{1'b0}}, SMW'(-s_r[k])} * {{SMW{1'b0}}, SMW'(-s_r[k])}
                            : {{SMW{1'b0}}, s_r[k]} * {{SMW{1'b0}}, s_r[k]};
    end
  end
  logic [E2W-1:0] mm;
  assign mm = E2W'(m_r) * E2W'(m_r);

  logic [E2W-1:0] q_w;
  assign q_w = E2W'(sq[0]) + E2W'(sq[1]) + E2W'(sq[2]);
  always_ff @(posedge clk) begin
    if (en) begin
      e2a_r <= mm + E2W'(a_r[0]) * E2W'(a_r[0]) + E2W'(a_r[1]) * E2W'(a_r[1])
             + E2W'(a_r[2]) * E2W'(a_r[2]);
      e2b_r <= mm + E2W'(a_r[3]) * E2W'(a_r[3]) + E2W'(a_r[4]) * E2W'(a_r[4])
             + E2W'(a_r[5]) * E2W'(a_r[5]);
      sd1_r <= q_w;
    end
  end

  logic [EW-1:0] ea, eb;
  logic [SW1-1:0] sd1a_o, sd1b_o;
  dim_sqrt_chain #(.RW(EW), .XW(E2W), .SW(SW1)) u_ea (
    .clk(clk), .en(en), .x_in(e2a_r), .side_in(sd1_r[EW-1:0]), .r_out(ea),
    .side_out(sd1a_o)
  );
  dim_sqrt_chain #(.RW(EW), .XW(E2W), .SW(SW1)) u_eb (
    .clk(clk), .en(en), .x_in(e2b_r), .side_in(sd1_r[E2W-1:EW]), .r_out(eb),
    .side_out(sd1b_o)
  );

  logic [M2W-1:0] ssum, qq;
  assign ssum = M2W'({1'b0, ea} + {1'b0, eb}) * M2W'({1'b0, ea} + {1'b0, eb});
  assign qq = M2W'({sd1b_o, sd1a_o});
  logic [M2W-1:0] d_r;
  logic [SW2-1:0] sd2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= (qq <= ssum) ? ssum - qq : '0;
      sd2_r <= {(qq > ssum), ea, eb};
    end
  end

  logic [MW-1:0] pm;
  logic [SW2-1:0] sd2_o;
  dim_sqrt_chain #(.RW(MW), .XW(M2W), .SW(SW2)) u_pm (
    .clk(clk), .en(en), .x_in(d_r), .side_in(sd2_r), .r_out(pm), .side_out(sd2_o)
  );

  logic [EW-1:0] fa, fb;
  assign fa = sd2_o[2*EW-1:EW];
  assign fb = sd2_o[EW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= '0;
      v2_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= {v1_r[L1-1:0], in_ch.valid};
      v2_r    <= {v2_r[EW-1:0], v1_r[L1]};
      out_v_r <= v2_r[EW];
    end
  end

  logic [PAIR_BITS-1:0] pm_o_r;
  logic [ENERGY_BITS-1:0] ea_o_r, eb_o_r;
  logic neg_o_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pm_o_r  <= (MW > PAIR_BITS && (pm >> PAIR_BITS) != '0) ? '1 : PAIR_BITS'(pm);
      ea_o_r  <= (EW > ENERGY_BITS && (fa >> ENERGY_BITS) != '0) ? '1 : ENERGY_BITS'(fa);
      eb_o_r  <= (EW > ENERGY_BITS && (fb >> ENERGY_BITS) != '0) ? '1 : ENERGY_BITS'(fb);
      neg_o_r <= sd2_o[SW2-1];
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = {neg_o_r, eb_o_r, ea_o_r, pm_o_r};
endmodule

// ----- tb/dimuon_invariant_mass_unit_test.sv -----
// Self-checking testbench for the dimuon invariant mass unit
module dimuon_invariant_mass_unit_test;
  import dim_pkg::*;

  localparam int MOM_BITS   = 20;
  localparam int IN_W       = 6 * MOM_BITS;
  localparam int OUT_W      = PAIR_BITS + 2 * ENERGY_BITS + 1;
  localparam int PIPE_LAT   = 2 * (MOM_BITS + 2) + 5;
  localparam int IDLE_LIMIT = 5000;
  localparam int MOM_MAX    = (1 << (MOM_BITS - 1)) - 1;
  localparam int MOM_MIN    = -(1 << (MOM_BITS - 1));
  localparam int MASS_TOP   = (1 << MASS_BITS) - 1;

  typedef struct packed {
    logic signed [MOM_BITS-1:0] plus_px;
    logic signed [MOM_BITS-1:0] plus_py;
    logic signed [MOM_BITS-1:0] plus_pz;
    logic signed [MOM_BITS-1:0] minus_px;
    logic signed [MOM_BITS-1:0] minus_py;
    logic signed [MOM_BITS-1:0] minus_pz;
  } pair_t;

  typedef struct packed {
    logic [PAIR_BITS-1:0]   pair_mass;
    logic [ENERGY_BITS-1:0] plus_energy;
    logic [ENERGY_BITS-1:0] minus_energy;
    logic                   mass_negative;
  } mass_result_t;

  typedef struct {
    logic [MASS_BITS-1:0] mass;
    pair_t                item;
    bit                   has_exp;
    mass_result_t         exp;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [MASS_BITS-1:0] cfg_wdata;

  dim_if #(.W(IN_W))  in_ch ();
  dim_if #(.W(OUT_W)) out_ch ();

  dimuon_invariant_mass_unit #(.MOMENTUM_BITS(MOM_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [MASS_BITS-1:0] mass_model;
  mass_result_t         mass_exp_q[$];
  mass_result_t         row_exp_q[$];
  bit                   row_chk_q[$];
  int                   mismatches;
  int                   burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] pair_to_bus(pair_t p);
    return {p.minus_pz, p.minus_py, p.minus_px, p.plus_pz, p.plus_py, p.plus_px};
  endfunction

  function automatic pair_t bus_to_pair(logic [IN_W-1:0] d);
    pair_t p;
    {p.minus_pz, p.minus_py, p.minus_px, p.plus_pz, p.plus_py, p.plus_px} = d;
    return p;
  endfunction

  function automatic mass_result_t bus_to_result(logic [OUT_W-1:0] d);
    mass_result_t r;
    {r.mass_negative, r.minus_energy, r.plus_energy, r.pair_mass} = d;
    return r;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic mass_result_t predict_pair(pair_t p, logic [MASS_BITS-1:0] m);
    longint          a1 [3];
    longint          a2 [3];
    longint unsigned e1;
    longint unsigned e2;
    longint unsigned s;
    longint unsigned q;
    longint unsigned r;
    mass_result_t    res;
    a1[0] = p.plus_px;  a1[1] = p.plus_py;  a1[2] = p.plus_pz;
    a2[0] = p.minus_px; a2[1] = p.minus_py; a2[2] = p.minus_pz;
    e1 = longint'(m) * longint'(m);
    e2 = e1;
    q  = 0;
    for (int k = 0; k < 3; k++) begin
      e1 += a1[k] * a1[k];
      e2 += a2[k] * a2[k];
      q  += (a1[k] + a2[k]) * (a1[k] + a2[k]);
    end
    e1 = floor_sqrt(e1);
    e2 = floor_sqrt(e2);
    s  = (e1 + e2) * (e1 + e2);
    res.mass_negative = (q > s);
    r = res.mass_negative ? 0 : floor_sqrt(s - q);
    res.pair_mass    = (r > (1 << PAIR_BITS) - 1) ? (1 << PAIR_BITS) - 1 : r;
    res.plus_energy  = (e1 > (1 << ENERGY_BITS) - 1) ? (1 << ENERGY_BITS) - 1 : e1;
    res.minus_energy = (e2 > (1 << ENERGY_BITS) - 1) ? (1 << ENERGY_BITS) - 1 : e2;
    return res;
  endfunction

  function automatic logic signed [MOM_BITS-1:0] rand_mom(int kind);
    unique case (kind)
      0:       return MOM_BITS'($urandom);
      1:       return MOM_BITS'($signed($urandom_range(0, 4000)) - 2000);
      2:       return ($urandom_range(0, 1)) ? MOM_BITS'(MOM_MAX) : MOM_BITS'(MOM_MIN);
      default: return MOM_BITS'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic send_pair(pair_t p);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= pair_to_bus(p);
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic load_mass(logic [MASS_BITS-1:0] m);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (mass_exp_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    mass_model = m;
    @(posedge clk);
    cfg_we <= 1'b0;
    burst_left = 0;
  endtask

  // checker, receiver stall pattern and watchdog
  initial begin
    mass_result_t got;
    mass_result_t want;
    bit           chk;
    mass_result_t fixed;
    int           idle;
    int           mode;
    idle = 0;
    mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        idle++;
        if (in_ch.valid && in_ch.ready) begin
          idle = 0;
          mass_exp_q.push_back(predict_pair(bus_to_pair(in_ch.data), mass_model));
        end
        if (out_ch.valid && out_ch.ready) begin
          idle = 0;
          got = bus_to_result(out_ch.data);
          if (mass_exp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %p", got);
          end else begin
            want  = mass_exp_q.pop_front();
            chk   = row_chk_q.size() ? row_chk_q.pop_front() : 1'b0;
            fixed = row_exp_q.size() ? row_exp_q.pop_front() : want;
            if (chk) want = fixed;
            if (got.pair_mass !== want.pair_mass || got.plus_energy !== want.plus_energy
                || got.minus_energy !== want.minus_energy
                || got.mass_negative !== want.mass_negative) begin
              mismatches++;
              if (mismatches <= 10)
                $display("mismatch: exp mass %0d e+ %0d e- %0d neg %0b, got %0d %0d %0d %0b",
                         want.pair_mass, want.plus_energy, want.minus_energy,
                         want.mass_negative, got.pair_mass, got.plus_energy,
                         got.minus_energy, got.mass_negative);
            end
          end
        end
        if (idle >= IDLE_LIMIT) begin
          $display("dimuon_invariant_mass_unit_test NOT OK");
          $finish;
        end
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      unique case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    dir_row_t             rows[$];
    dir_row_t             row;
    pair_t                p;
    logic [MASS_BITS-1:0] masses[6];
    int                   kind;
    mismatches  = 0;
    burst_left  = 0;
    mass_model  = 106;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    row.mass = 106; row.has_exp = 1;
    row.item = '0; row.exp = '{212, 106, 106, 0}; rows.push_back(row);
    row.item = '{1000, 0, 0, -1000, 0, 0}; row.exp = '{2010, 1005, 1005, 0}; rows.push_back(row);
    row.has_exp = 0;
    row.item = '{MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX}; rows.push_back(row);
    row.item = '{MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN}; rows.push_back(row);
    row.item = '{MOM_MAX, MOM_MAX, MOM_MAX, MOM_MIN, MOM_MIN, MOM_MIN}; rows.push_back(row);
    row.item = '{MOM_MIN, 0, MOM_MAX, MOM_MAX, MOM_MIN, 0}; rows.push_back(row);
    row.item = '{-1, 1, -1, 1, -1, 1}; rows.push_back(row);
    row.mass = 0; row.has_exp = 1;
    row.item = '0; row.exp = '{0, 0, 0, 0}; rows.push_back(row);
    row.item = '{1, 1, 0, 1, 1, 0}; row.exp = '{0, 1, 1, 1}; rows.push_back(row);
    row.item = '{3, 4, 0, -3, -4, 0}; row.exp = '{10, 5, 5, 0}; rows.push_back(row);
    row.has_exp = 0;
    row.item = '{MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX}; rows.push_back(row);
    row.item = '{7, -3, 2, 7, -3, 2}; rows.push_back(row);
    row.mass = MASS_BITS'(MASS_TOP); row.has_exp = 1;
    row.item = '0;
    row.exp = '{PAIR_BITS'(2 * MASS_TOP), ENERGY_BITS'(MASS_TOP), ENERGY_BITS'(MASS_TOP), 0};
    rows.push_back(row);
    row.has_exp = 0;
    row.item = '{MOM_MAX, MOM_MAX, MOM_MAX, MOM_MIN, MOM_MIN, MOM_MIN}; rows.push_back(row);
    row.item = '{MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN}; rows.push_back(row);

    foreach (rows[i]) begin
      if (i == 0 || rows[i].mass != rows[i-1].mass) load_mass(rows[i].mass);
      row_chk_q.push_back(rows[i].has_exp);
      row_exp_q.push_back(rows[i].exp);
      send_pair(rows[i].item);
    end
    load_mass(mass_model);
    row_chk_q.delete();
    row_exp_q.delete();

    masses = '{106, 0, MASS_BITS'(MASS_TOP), MASS_BITS'($urandom),
               MASS_BITS'($urandom_range(0, 200)), 938};
    foreach (masses[m]) begin
      load_mass(masses[m]);
      repeat (210) begin
        kind = $urandom_range(0, 9);
        p.plus_px  = rand_mom(kind % 4); p.plus_py  = rand_mom(kind % 4);
        p.plus_pz  = rand_mom(kind % 4);
        if (kind == 8) begin
          p.minus_px = -p.plus_px; p.minus_py = -p.plus_py; p.minus_pz = -p.plus_pz;
        end else if (kind == 9) begin
          p.minus_px = p.plus_px; p.minus_py = p.plus_py; p.minus_pz = p.plus_pz;
        end else begin
          p.minus_px = rand_mom(kind % 4); p.minus_py = rand_mom(kind % 4);
          p.minus_pz = rand_mom(kind % 4);
        end
        send_pair(p);
      end
    end
    in_ch.valid <= 1'b0;
    while (mass_exp_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("dimuon_invariant_mass_unit_test OK");
    end else begin
      $display("dimuon_invariant_mass_unit_test NOT OK");
    end
    $finish;
  end
endmodule
